[sv/ldsm_pkg.sv]
package ldsm_pkg;

  // Field and register widths
  localparam int DistW    = 21;
  localparam int SpeedW   = 18;
  localparam int AccelW   = 17;
  localparam int TgtW     = 17;
  localparam int CfgDistW = 20;
  localparam int VelLimW  = 17;
  localparam int AccLimW  = 16;
  localparam int WaitW    = 16;
  localparam int EnW      = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int ModeW    = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_DEPART_STOP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEPART_OFFSET = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STOPPING      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VEL_LIMIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACC_LIMIT     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WAIT_PERIODS  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OVERSHOOT     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FEATURES      = 3'd7;

  // Feature enable bit positions
  localparam int FEAT_SMOOTH    = 0;
  localparam int FEAT_OVERSHOOT = 1;
  localparam int FEAT_KEEP      = 2;

  // Reset values of the registers
  localparam logic [CfgDistW-1:0] RST_DEPART_STOP   = 20'd500;
  localparam logic [CfgDistW-1:0] RST_DEPART_OFFSET = 20'd1000;
  localparam logic [CfgDistW-1:0] RST_STOPPING      = 20'd500;
  localparam logic [VelLimW-1:0]  RST_VEL_LIMIT     = 17'd10;
  localparam logic [AccLimW-1:0]  RST_ACC_LIMIT     = 16'd100;
  localparam logic [WaitW-1:0]    RST_WAIT_PERIODS  = 16'd3;
  localparam logic [CfgDistW-1:0] RST_OVERSHOOT     = 20'd1500;
  localparam logic [EnW-1:0]      RST_FEATURES      = 3'd3;

  typedef struct packed {
    logic [CfgDistW-1:0] depart_stop;
    logic [CfgDistW-1:0] depart_offset;
    logic [CfgDistW-1:0] stopping;
    logic [VelLimW-1:0]  vel_limit;
    logic [AccLimW-1:0]  acc_limit;
    logic [WaitW-1:0]    wait_periods;
    logic [CfgDistW-1:0] overshoot;
    logic [EnW-1:0]      features;
  } ldsm_cfg_t;

  // Per-period conditions handed from the evaluator to the mode machine
  typedef struct packed {
    logic far;
    logic ctrl;
    logic not_running;
    logic dep_stopping;
    logic dep_stopped;
    logic keep;
    logic stopping;
    logic emerg;
    logic smooth_en;
  } ldsm_cond_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             mode_changed;
    logic             smooth_stop_start;
    logic             restart_drive;
    logic             keep_stopped;
  } ldsm_res_t;

endpackage

[sv/longitudinal_drive_state_machine_unit.sv]
// Path: a beat accepted into the input register is evaluated and mode-updated combinationally,
// and its result is captured in the output register, from which the result beat is taken.
// Throughput: one beat per cycle unless out_stall holds a full output register; the input and
// output registers each pass one beat per cycle around a single compare-and-select mode update.
// Reset (rst, synchronous): mode goes to stopped, the running history and idle count clear,
// both pipeline stages empty, and configuration returns to its reset values.
module longitudinal_drive_state_machine_unit
  import ldsm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DistW-1:0]  stop_distance,
  input  logic signed [SpeedW-1:0] speed,
  input  logic signed [AccelW-1:0] accel,
  input  logic [TgtW-1:0]          nearest_target_speed,
  input  logic                     gear_forward,
  input  logic                     steer_converged,
  input  logic                     under_control,
  input  logic                     far_from_path,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ModeW-1:0]         mode,
  output logic                     mode_changed,
  output logic                     smooth_stop_start,
  output logic                     restart_drive,
  output logic                     keep_stopped
);

  ldsm_cfg_t               cfg;
  logic                    s1_valid;
  logic signed [DistW-1:0]  s1_dist;
  logic signed [SpeedW-1:0] s1_speed;
  logic signed [AccelW-1:0] s1_accel;
  logic [TgtW-1:0]         s1_tgt;
  logic                    s1_fwd;
  logic                    s1_steer;
  logic                    s1_ctrl;
  logic                    s1_far;
  logic                    advance;
  ldsm_cond_t              cond;
  ldsm_res_t               res;
  ldsm_res_t               out_res;

  // Move a beat to the output register when it is empty or being taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depart_stop   <= RST_DEPART_STOP;
      cfg.depart_offset <= RST_DEPART_OFFSET;
      cfg.stopping      <= RST_STOPPING;
      cfg.vel_limit     <= RST_VEL_LIMIT;
      cfg.acc_limit     <= RST_ACC_LIMIT;
      cfg.wait_periods  <= RST_WAIT_PERIODS;
      cfg.overshoot     <= RST_OVERSHOOT;
      cfg.features      <= RST_FEATURES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEPART_STOP:   cfg.depart_stop   <= cfg_data;
        REG_DEPART_OFFSET: cfg.depart_offset <= cfg_data;
        REG_STOPPING:      cfg.stopping      <= cfg_data;
        REG_VEL_LIMIT:     cfg.vel_limit     <= cfg_data[VelLimW-1:0];
        REG_ACC_LIMIT:     cfg.acc_limit     <= cfg_data[AccLimW-1:0];
        REG_WAIT_PERIODS:  cfg.wait_periods  <= cfg_data[WaitW-1:0];
        REG_OVERSHOOT:     cfg.overshoot     <= cfg_data;
        REG_FEATURES:      cfg.features      <= cfg_data[EnW-1:0];
        default:           cfg.features      <= cfg.features;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_dist  <= stop_distance;
      s1_speed <= speed;
      s1_accel <= accel;
      s1_tgt   <= nearest_target_speed;
      s1_fwd   <= gear_forward;
      s1_steer <= steer_converged;
      s1_ctrl  <= under_control;
      s1_far   <= far_from_path;
    end
  end

  ldsm_eval u_eval (
    .stop_distance        (s1_dist),
    .speed                (s1_speed),
    .accel                (s1_accel),
    .nearest_target_speed (s1_tgt),
    .gear_forward         (s1_fwd),
    .steer_converged      (s1_steer),
    .under_control        (s1_ctrl),
    .far_from_path        (s1_far),
    .cfg                  (cfg),
    .cond                 (cond)
  );

  ldsm_mode_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .cond         (cond),
    .wait_periods (cfg.wait_periods),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign mode              = out_res.mode;
  assign mode_changed      = out_res.mode_changed;
  assign smooth_stop_start = out_res.smooth_stop_start;
  assign restart_drive     = out_res.restart_drive;
  assign keep_stopped      = out_res.keep_stopped;

endmodule

[sv/ldsm_eval.sv]
module ldsm_eval
  import ldsm_pkg::*;
(
  input  logic signed [DistW-1:0]  stop_distance,
  input  logic signed [SpeedW-1:0] speed,
  input  logic signed [AccelW-1:0] accel,
  input  logic [TgtW-1:0]          nearest_target_speed,
  input  logic                     gear_forward,
  input  logic                     steer_converged,
  input  logic                     under_control,
  input  logic                     far_from_path,
  input  ldsm_cfg_t                cfg,
  output ldsm_cond_t               cond
);

  logic [SpeedW-1:0]       speed_mag;
  logic [AccelW-1:0]       accel_mag;
  logic                    halted;
  logic                    speed_neg;
  logic                    speed_pos;
  logic signed [DistW+1:0] dist_x;
  logic [CfgDistW:0]       depart_sum;
  logic signed [DistW+1:0] overshoot_neg;

  // Magnitudes of speed and acceleration, full range kept unsigned
  assign speed_mag = speed[SpeedW-1] ? $unsigned(-speed) : $unsigned(speed);
  assign accel_mag = accel[AccelW-1] ? $unsigned(-accel) : $unsigned(accel);

  assign halted    = (speed_mag < {1'b0, cfg.vel_limit}) &&
                     (accel_mag < {1'b0, cfg.acc_limit});
  assign speed_neg = speed[SpeedW-1];
  assign speed_pos = !speed[SpeedW-1] && (speed != '0);

  // Distance thresholds, compared at two extra bits
  assign dist_x        = {{2{stop_distance[DistW-1]}}, stop_distance};
  assign depart_sum    = {1'b0, cfg.depart_stop} + {1'b0, cfg.depart_offset};
  assign overshoot_neg = -$signed({3'b000, cfg.overshoot});

  always_comb begin
    cond.far          = far_from_path;
    cond.ctrl         = under_control;
    cond.not_running  = gear_forward ? (halted || speed_neg) : (halted || speed_pos);
    cond.dep_stopping = dist_x > $signed({2'b00, depart_sum});
    cond.dep_stopped  = dist_x > $signed({3'b000, cfg.depart_stop});
    cond.stopping     = dist_x < $signed({3'b000, cfg.stopping});
    cond.keep         = (speed == '0) && cfg.features[FEAT_KEEP] && !steer_converged;
    cond.emerg        = cfg.features[FEAT_OVERSHOOT] && (dist_x < overshoot_neg) &&
                        (nearest_target_speed == '0);
    cond.smooth_en    = cfg.features[FEAT_SMOOTH];
  end

endmodule

[sv/ldsm_mode_fsm.sv]
module ldsm_mode_fsm
  import ldsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ldsm_cond_t       cond,
  input  logic [WaitW-1:0] wait_periods,
  output ldsm_res_t        res
);

  typedef enum logic [ModeW-1:0] {
    DRIVE     = 2'd0,
    STOPPING  = 2'd1,
    STOPPED   = 2'd2,
    EMERGENCY = 2'd3
  } mode_t;

  mode_t            mode;
  mode_t            mode_next;
  logic             seen_running;
  logic             seen_running_next;
  logic [WaitW-1:0] idle_periods;
  logic [WaitW-1:0] idle_periods_next;
  logic             running;
  logic             stopped_cond;
  logic             ss_start;
  logic             restart;
  logic             hold;

  // Track periods since the vehicle was last running
  assign running           = !cond.far && !cond.not_running;
  assign seen_running_next = seen_running || running;

  always_comb begin
    idle_periods_next = idle_periods;
    if (running) begin
      idle_periods_next = '0;
    end else if (seen_running && (idle_periods != '1)) begin
      idle_periods_next = idle_periods + 1'b1;
    end
  end

  assign stopped_cond = seen_running_next && (idle_periods_next > wait_periods);

  // Mode transitions
  always_comb begin
    mode_next = mode;
    ss_start  = 1'b0;
    restart   = 1'b0;
    hold      = 1'b0;
    if (!cond.far) begin
      unique case (mode)
        DRIVE: begin
          priority if (cond.emerg) begin
            mode_next = EMERGENCY;
          end else if (!cond.ctrl && stopped_cond && cond.keep) begin
            mode_next = STOPPED;
          end else if (cond.smooth_en) begin
            if (cond.stopping) begin
              mode_next = STOPPING;
              ss_start  = 1'b1;
            end
          end else if (stopped_cond && !cond.dep_stopped) begin
            mode_next = STOPPED;
          end else begin
            mode_next = mode;
          end
        end
        STOPPING: begin
          priority if (cond.emerg) begin
            mode_next = EMERGENCY;
          end else if (stopped_cond) begin
            mode_next = STOPPED;
          end else if (cond.dep_stopping) begin
            mode_next = DRIVE;
            restart   = 1'b1;
          end else begin
            mode_next = mode;
          end
        end
        STOPPED: begin
          priority if (cond.keep) begin
            hold = 1'b1;
          end else if (cond.dep_stopped) begin
            mode_next = DRIVE;
            restart   = 1'b1;
          end else begin
            mode_next = mode;
          end
        end
        EMERGENCY: begin
          priority if (stopped_cond) begin
            mode_next = STOPPED;
          end else if (!cond.emerg && !cond.ctrl) begin
            mode_next = DRIVE;
          end else begin
            mode_next = mode;
          end
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_comb begin
    res.mode              = mode_next;
    res.mode_changed      = (mode_next != mode);
    res.smooth_stop_start = ss_start;
    res.restart_drive     = restart;
    res.keep_stopped      = hold;
  end

  // Hold state; advance once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= STOPPED;
      seen_running <= 1'b0;
      idle_periods <= '0;
    end else if (advance) begin
      mode         <= mode_next;
      seen_running <= seen_running_next;
      idle_periods <= idle_periods_next;
    end
  end

  a_restart_to_drive: assert property (@(posedge clk) disable iff (rst)
    res.restart_drive |-> (mode_next == DRIVE) && (mode == STOPPING || mode == STOPPED))
    else $error("restart strobe without a departure to drive");

  a_smooth_from_drive: assert property (@(posedge clk) disable iff (rst)
    res.smooth_stop_start |-> (mode == DRIVE) && (mode_next == STOPPING))
    else $error("smooth stop strobe without drive to stopping");

  a_keep_in_stopped: assert property (@(posedge clk) disable iff (rst)
    res.keep_stopped |-> (mode == STOPPED) && !res.mode_changed)
    else $error("keep stopped strobe outside stopped mode");

  a_idle_before_running: assert property (@(posedge clk) disable iff (rst)
    !seen_running |-> (idle_periods == '0))
    else $error("idle count moved before running was seen");

  a_running_clears_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && running) |=> (idle_periods == '0) && seen_running)
    else $error("running period did not clear the idle count");

endmodule
